FILE: rtl/compressor_start_and_protect_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Compressor start and protect controller: assertion macros
// Shared macros for the concurrent checks on the controller ports.
// ----------------------------------------------------------------------------
`ifndef COMPRESSOR_START_AND_PROTECT_CONTROLLER_UNIT_ASSERT_SVH
`define COMPRESSOR_START_AND_PROTECT_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cspc_pkg.sv
// ----------------------------------------------------------------------------
// Compressor start and protect controller: package
// Field layout of the stream words, register indexes, reset values and codes.
// ----------------------------------------------------------------------------
package cspc_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USED_W  = 42;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int VOLT_W = 14;
    localparam int TEMP_W = 12;
    localparam int FREQ_W = 12;
    localparam int TICK_W = 16;
    localparam int FLT_W  = 4;
    localparam int SEQ_W  = 2;

    // Input word layout, lowest bit first.
    localparam int IN_VDC_LSB   = 0;
    localparam int IN_PHASE_BIT = 14;
    localparam int IN_OC_BIT    = 15;
    localparam int IN_OT_BIT    = 16;
    localparam int IN_ON_BIT    = 17;
    localparam int IN_CAB_LSB   = 18;
    localparam int IN_AMB_LSB   = 30;

    localparam logic [CFG_ADDR_W-1:0] REG_DC_VOLTAGE_MIN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_SETPOINT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_SPAN_HIGH   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_SPAN_LOW    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FREQ_MINIMUM      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FREQ_START        = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_WARMUP_LEN        = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_HEATER_TEMP_LIMIT = 3'd7;

    localparam logic [VOLT_W-1:0]        RST_DC_VOLTAGE_MIN    = 14'd0;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_SETPOINT     = 12'sd0;
    localparam logic signed [TEMP_W-1:0] RST_ERROR_SPAN_HIGH   = 12'sd50;
    localparam logic signed [TEMP_W-1:0] RST_ERROR_SPAN_LOW    = 12'sd0;
    localparam logic [FREQ_W-1:0]        RST_FREQ_MINIMUM      = 12'd300;
    localparam logic [FREQ_W-1:0]        RST_FREQ_START        = 12'd1250;
    localparam logic [TICK_W-1:0]        RST_WARMUP_LEN        = 16'd0;
    localparam logic signed [TEMP_W-1:0] RST_HEATER_TEMP_LIMIT = 12'sd100;

    localparam logic [SEQ_W-1:0] SEQ_IDLE = 2'd0;
    localparam logic [SEQ_W-1:0] SEQ_WARM = 2'd1;
    localparam logic [SEQ_W-1:0] SEQ_RUN  = 2'd2;
    localparam logic [SEQ_W-1:0] SEQ_STOP = 2'd3;

    // Bit-serial multiply and divide each take one step per operand bit.
    localparam int STEPS = FREQ_W;
    localparam int CNT_W = $clog2(STEPS);

endpackage

FILE: rtl/cspc_interp.sv
// ----------------------------------------------------------------------------
// Compressor start and protect controller: frequency interpolator
// Bit-serial shift-add multiply, restoring divide and final offset.
// ----------------------------------------------------------------------------
module cspc_interp
    import cspc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [FREQ_W-1:0]        span_pos,
    input  logic signed [FREQ_W:0]   freq_delta,
    input  logic [FREQ_W-1:0]        span_den,
    input  logic [FREQ_W-1:0]        freq_base,
    output logic                     done,
    output logic [FREQ_W-1:0]        freq
);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_FIN  = 2'd3;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic [1:0]            st_reg, st_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [2*FREQ_W-1:0]   p_reg, p_next;
    logic [FREQ_W-1:0]     a_reg, a_next;
    logic [FREQ_W-1:0]     den_reg, den_next;
    logic [FREQ_W-1:0]     base_reg, base_next;
    logic                  neg_reg, neg_next;
    logic [FREQ_W-1:0]     freq_reg, freq_next;
    logic                  done_reg, done_next;

    logic [FREQ_W:0]       mag;
    logic [FREQ_W:0]       addend;
    logic [FREQ_W:0]       trial;
    logic                  fits;
    logic [FREQ_W:0]       diff;
    logic [FREQ_W-1:0]     quot;

    always_comb
    begin
        mag    = freq_delta[FREQ_W] ? (~freq_delta + 1'b1) : freq_delta;
        addend = p_reg[0] ? ({1'b0, p_reg[2*FREQ_W-1:FREQ_W]} + {1'b0, a_reg})
                          : {1'b0, p_reg[2*FREQ_W-1:FREQ_W]};
        trial  = {p_reg[2*FREQ_W-1:FREQ_W], p_reg[FREQ_W-1]};
        fits   = trial >= {1'b0, den_reg};
        diff   = trial - {1'b0, den_reg};
        quot   = p_reg[FREQ_W-1:0];

        st_next   = st_reg;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        a_next    = a_reg;
        den_next  = den_reg;
        base_next = base_reg;
        neg_next  = neg_reg;
        freq_next = freq_reg;
        done_next = 1'b0;

        case (st_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    a_next    = span_pos;
                    p_next    = {{FREQ_W{1'b0}}, mag[FREQ_W-1:0]};
                    den_next  = span_den;
                    base_next = freq_base;
                    neg_next  = freq_delta[FREQ_W];
                    cnt_next  = '0;
                    st_next   = U_MUL;
                end
            end
            U_MUL:
            begin
                p_next   = {addend, p_reg[FREQ_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next = '0;
                    st_next  = U_DIV;
                end
            end
            U_DIV:
            begin
                p_next   = {(fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0]),
                            p_reg[FREQ_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next = '0;
                    st_next  = U_FIN;
                end
            end
            U_FIN:
            begin
                freq_next = neg_reg ? (base_reg - quot) : (base_reg + quot);
                done_next = 1'b1;
                st_next   = U_IDLE;
            end
            default:
            begin
                st_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= U_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        a_reg    <= a_next;
        den_reg  <= den_next;
        base_reg <= base_next;
        neg_reg  <= neg_next;
        freq_reg <= freq_next;
    end

    assign done = done_reg;
    assign freq = freq_reg;

endmodule

FILE: rtl/compressor_start_and_protect_controller_unit.sv
// ----------------------------------------------------------------------------
// Compressor start and protect controller
// Per-tick fault monitor, compressor sequencer, frequency mapping, oil heater.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel is one control tick; it produces exactly
// one result request on the m_axis channel, in order.
// The block handles one tick at a time. s_axis_tready is high only while no
// tick is being evaluated. A tick that needs no frequency interpolation goes
// through the evaluate and done states to the result register. A tick that
// runs in the interpolation band also passes through the wait state, for the
// interpolator's bit-serial multiply, bit-serial divide and final offset.
// The next tick is taken in the cycle after the result register loads.
// Results wait in an output register; the next tick is accepted while a
// result waits, and its evaluation holds before the result register until
// the receiver takes the previous result.
// The configuration port writes one register per cycle; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Reset restores all register defaults, clears the sequence, faults, notify
// flag, frequency and error, and empties the output register.
// ----------------------------------------------------------------------------
module compressor_start_and_protect_controller_unit
    import cspc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wen,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // dc_voltage, ac_phase_fault, drive_overcurrent, drive_overheat,
    // system_on, cabinet_temp, ambient_temp, zero fill
    input  logic [IN_DATA_W-1:0]     s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // compressor_on, sequence_state, warmup_complete, fault_flags,
    // notify_user, compressor_freq, temp_error, oil_heater_on, zero fill
    output logic [OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_EVAL = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    logic [VOLT_W-1:0]        dc_min_reg, dc_min_next;
    logic signed [TEMP_W-1:0] setpoint_reg, setpoint_next;
    logic signed [TEMP_W-1:0] span_hi_reg, span_hi_next;
    logic signed [TEMP_W-1:0] span_lo_reg, span_lo_next;
    logic [FREQ_W-1:0]        fmin_reg, fmin_next;
    logic [FREQ_W-1:0]        fstart_reg, fstart_next;
    logic [TICK_W-1:0]        ticks_reg, ticks_next;
    logic signed [TEMP_W-1:0] heat_lim_reg, heat_lim_next;

    logic [1:0]               phase_reg, phase_next;
    logic [IN_USED_W-1:0]     in_reg, in_next;
    logic [SEQ_W-1:0]         seq_reg, seq_next;
    logic [TICK_W-1:0]        count_reg, count_next;
    logic                     wflag_reg, wflag_next;
    logic [FLT_W-1:0]         fault_reg, fault_next;
    logic                     notify_reg, notify_next;
    logic [FREQ_W-1:0]        freq_reg, freq_next;
    logic signed [TEMP_W-1:0] error_reg, error_next;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]    m_data_reg, m_data_next;

    logic [VOLT_W-1:0]        vdc;
    logic                     sys_on;
    logic signed [TEMP_W-1:0] cab;
    logic signed [TEMP_W-1:0] amb;
    logic [FLT_W-1:0]         fault_now;
    logic                     any_fault;
    logic signed [TEMP_W:0]   d;
    logic signed [TEMP_W+1:0] pos_full;
    logic signed [TEMP_W:0]   den_full;
    logic signed [FREQ_W:0]   fdelta;
    logic                     at_high;
    logic                     at_low;
    logic signed [TEMP_W-1:0] d_sat;
    logic [TICK_W-1:0]        count_inc;
    logic                     comp_on;
    logic                     heater_on;
    logic                     u_start;
    logic                     u_done;
    logic [FREQ_W-1:0]        u_freq;

    cspc_interp u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (u_start),
        .span_pos   (pos_full[FREQ_W-1:0]),
        .freq_delta (fdelta),
        .span_den   (den_full[FREQ_W-1:0]),
        .freq_base  (fmin_reg),
        .done       (u_done),
        .freq       (u_freq)
    );

    always_comb
    begin
        vdc    = in_reg[IN_VDC_LSB +: VOLT_W];
        sys_on = in_reg[IN_ON_BIT];
        cab    = in_reg[IN_CAB_LSB +: TEMP_W];
        amb    = in_reg[IN_AMB_LSB +: TEMP_W];

        fault_now = {in_reg[IN_OT_BIT], in_reg[IN_OC_BIT], in_reg[IN_PHASE_BIT],
                     (vdc < dc_min_reg)};
        any_fault = |fault_now;

        d        = {cab[TEMP_W-1], cab} - {setpoint_reg[TEMP_W-1], setpoint_reg};
        pos_full = {d[TEMP_W], d} - {{2{span_lo_reg[TEMP_W-1]}}, span_lo_reg};
        den_full = {span_hi_reg[TEMP_W-1], span_hi_reg}
                 - {span_lo_reg[TEMP_W-1], span_lo_reg};
        fdelta   = $signed({1'b0, fstart_reg}) - $signed({1'b0, fmin_reg});
        at_high  = d >= $signed({span_hi_reg[TEMP_W-1], span_hi_reg});
        at_low   = d <= $signed({span_lo_reg[TEMP_W-1], span_lo_reg});

        if (d[TEMP_W] != d[TEMP_W-1])
        begin
            d_sat = d[TEMP_W] ? {1'b1, {(TEMP_W-1){1'b0}}} : {1'b0, {(TEMP_W-1){1'b1}}};
        end
        else
        begin
            d_sat = d[TEMP_W-1:0];
        end

        count_inc = (count_reg != TICK_MAX) ? (count_reg + 1'b1) : count_reg;
        comp_on   = (seq_reg == SEQ_WARM) || (seq_reg == SEQ_RUN);
        heater_on = !comp_on && (amb <= heat_lim_reg);
    end

    always_comb
    begin
        dc_min_next   = dc_min_reg;
        setpoint_next = setpoint_reg;
        span_hi_next  = span_hi_reg;
        span_lo_next  = span_lo_reg;
        fmin_next     = fmin_reg;
        fstart_next   = fstart_reg;
        ticks_next    = ticks_reg;
        heat_lim_next = heat_lim_reg;

        if (cfg_wen)
        begin
            case (cfg_addr)
                REG_DC_VOLTAGE_MIN:    dc_min_next   = cfg_data[VOLT_W-1:0];
                REG_TEMP_SETPOINT:     setpoint_next = cfg_data[TEMP_W-1:0];
                REG_ERROR_SPAN_HIGH:   span_hi_next  = cfg_data[TEMP_W-1:0];
                REG_ERROR_SPAN_LOW:    span_lo_next  = cfg_data[TEMP_W-1:0];
                REG_FREQ_MINIMUM:      fmin_next     = cfg_data[FREQ_W-1:0];
                REG_FREQ_START:        fstart_next   = cfg_data[FREQ_W-1:0];
                REG_WARMUP_LEN:        ticks_next    = cfg_data[TICK_W-1:0];
                REG_HEATER_TEMP_LIMIT: heat_lim_next = cfg_data[TEMP_W-1:0];
                default:               ticks_next    = ticks_reg;
            endcase
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        in_next      = in_reg;
        seq_next     = seq_reg;
        count_next   = count_reg;
        wflag_next   = wflag_reg;
        fault_next   = fault_reg;
        notify_next  = notify_reg;
        freq_next    = freq_reg;
        error_next   = error_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        u_start      = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_next    = s_axis_tdata[IN_USED_W-1:0];
                    phase_next = PH_EVAL;
                end
            end
            PH_EVAL:
            begin
                fault_next = fault_now;
                if (any_fault)
                begin
                    notify_next = 1'b1;
                end
                phase_next = PH_DONE;
                case (seq_reg)
                    SEQ_IDLE:
                    begin
                        if (sys_on && !any_fault)
                        begin
                            seq_next   = SEQ_WARM;
                            count_next = '0;
                            wflag_next = 1'b0;
                            freq_next  = fstart_reg;
                        end
                    end
                    SEQ_WARM:
                    begin
                        if (any_fault)
                        begin
                            seq_next = SEQ_STOP;
                        end
                        else
                        begin
                            count_next = count_inc;
                            if (count_inc >= ticks_reg)
                            begin
                                wflag_next = 1'b1;
                                seq_next   = SEQ_RUN;
                            end
                        end
                    end
                    SEQ_RUN:
                    begin
                        if (any_fault || !sys_on)
                        begin
                            seq_next = SEQ_STOP;
                        end
                        else
                        begin
                            error_next = d_sat;
                            if (at_high)
                            begin
                                freq_next = fstart_reg;
                            end
                            else if (at_low)
                            begin
                                freq_next = fmin_reg;
                            end
                            else
                            begin
                                u_start    = 1'b1;
                                phase_next = PH_WAIT;
                            end
                        end
                    end
                    default:
                    begin
                        wflag_next = 1'b0;
                        if (!any_fault)
                        begin
                            seq_next = SEQ_IDLE;
                        end
                    end
                endcase
            end
            PH_WAIT:
            begin
                if (u_done)
                begin
                    freq_next  = u_freq;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next  = {{(OUT_DATA_W-34){1'b0}}, heater_on, error_reg, freq_reg,
                                    notify_reg, fault_reg, wflag_reg, seq_reg, comp_on};
                    m_valid_next = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_min_reg   <= RST_DC_VOLTAGE_MIN;
            setpoint_reg <= RST_TEMP_SETPOINT;
            span_hi_reg  <= RST_ERROR_SPAN_HIGH;
            span_lo_reg  <= RST_ERROR_SPAN_LOW;
            fmin_reg     <= RST_FREQ_MINIMUM;
            fstart_reg   <= RST_FREQ_START;
            ticks_reg    <= RST_WARMUP_LEN;
            heat_lim_reg <= RST_HEATER_TEMP_LIMIT;
            phase_reg    <= PH_IDLE;
            seq_reg      <= SEQ_IDLE;
            count_reg    <= '0;
            wflag_reg    <= 1'b0;
            fault_reg    <= '0;
            notify_reg   <= 1'b0;
            freq_reg     <= '0;
            error_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            dc_min_reg   <= dc_min_next;
            setpoint_reg <= setpoint_next;
            span_hi_reg  <= span_hi_next;
            span_lo_reg  <= span_lo_next;
            fmin_reg     <= fmin_next;
            fstart_reg   <= fstart_next;
            ticks_reg    <= ticks_next;
            heat_lim_reg <= heat_lim_next;
            phase_reg    <= phase_next;
            seq_reg      <= seq_next;
            count_reg    <= count_next;
            wflag_reg    <= wflag_next;
            fault_reg    <= fault_next;
            notify_reg   <= notify_next;
            freq_reg     <= freq_next;
            error_reg    <= error_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        m_data_reg <= m_data_next;
    end

    assign s_axis_tready = (phase_reg == PH_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

FILE: rtl/cspc_checker.sv
// ----------------------------------------------------------------------------
// Compressor start and protect controller: port checker
// Concurrent checks on the stream ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "compressor_start_and_protect_controller_unit_assert.svh"

module cspc_checker
    import cspc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [OUT_DATA_W-1:0]    m_axis_tdata
);

    `CSPC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Stalled result changed")

    `CSPC_ASSERT_NEXT(a_one_tick, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "Second tick accepted during evaluation")

    `CSPC_ASSERT_SAME(a_on_state, clk, rst_n, m_axis_tvalid, m_axis_tdata[0] == ((m_axis_tdata[2:1] == SEQ_WARM) || (m_axis_tdata[2:1] == SEQ_RUN)), "Compressor on disagrees with state")

    `CSPC_ASSERT_SAME(a_fault_off, clk, rst_n, m_axis_tvalid && (m_axis_tdata[7:4] != 4'd0), m_axis_tdata[8] && !m_axis_tdata[0], "Fault did not stop compressor or notify")

    `CSPC_ASSERT_SAME(a_heater_off, clk, rst_n, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[33], "Oil heater on while compressor runs")

endmodule

bind compressor_start_and_protect_controller_unit cspc_checker u_cspc_checker (.*);
